// ----- hdl/rdm_pkg.sv -----
// Shared types, codes and helper functions for the random depth-first maze generator.
// No dependencies; compiled first.
package rdm_pkg;

  typedef struct packed {
    logic              mode;
    logic signed [7:0] row;
    logic signed [7:0] col;
    logic [2:0]        direction;
    logic [31:0]       seed;
  } in_t;

  typedef struct packed {
    logic       done_res;
    logic       in_range;
    logic [3:0] walls;
    logic       can_move;
  } out_t;

  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [2:0] DIR_NORTH = 3'd0;
  localparam logic [2:0] DIR_SOUTH = 3'd1;
  localparam logic [2:0] DIR_EAST  = 3'd2;
  localparam logic [2:0] DIR_WEST  = 3'd3;

  localparam logic [3:0] WALL_N   = 4'b0001;
  localparam logic [3:0] WALL_E   = 4'b0010;
  localparam logic [3:0] WALL_S   = 4'b0100;
  localparam logic [3:0] WALL_W   = 4'b1000;
  localparam logic [3:0] WALL_ALL = 4'b1111;

  typedef enum logic [1:0] {
    NB_N = 2'd0,
    NB_S = 2'd1,
    NB_E = 2'd2,
    NB_W = 2'd3
  } nb_dir_t;

  // Remainder unit: 32-bit dividend, divisor up to 64, four bits per cycle.
  localparam int MOD_DW     = 7;
  localparam int MOD_RW     = 6;
  localparam int MOD_CYCLES = 8;

  typedef struct packed {
    logic              start;
    logic [31:0]       value;
    logic [MOD_DW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [MOD_RW-1:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [3:0] wall_mine(input nb_dir_t d);
    logic [3:0] w;
    unique case (d)
      NB_N: w = WALL_N;
      NB_S: w = WALL_S;
      NB_E: w = WALL_E;
      NB_W: w = WALL_W;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] wall_theirs(input nb_dir_t d);
    logic [3:0] w;
    unique case (d)
      NB_N: w = WALL_S;
      NB_S: w = WALL_N;
      NB_E: w = WALL_W;
      NB_W: w = WALL_E;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/random_dfs_maze_generator.sv -----
// Random depth-first maze generator: cell memory, path stack and carving sequencer.
// Depends on rdm_pkg and rdm_mod.
//
// A generate item runs a wall reset sweep over all ROWS * COLS cells, then per carved
// cell a neighbor scan of the cell memory, a draw through the remainder unit and the
// wall update states CV0, CV1 and CV2, and per backtrack a scan plus a stack reload.
// busy stays high while an item is at work. Each result appears for one cycle under
// strobe; the receiver must take it then.
module random_dfs_maze_generator #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rdm_pkg::in_t  request,
  output logic          strobe,
  output rdm_pkg::out_t response
);
  import rdm_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int IW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DW    = $clog2(CELLS + 1);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_CLEAR = 15'h0002,
    ST_RDRAW = 15'h0004,
    ST_RWAIT = 15'h0008,
    ST_CDRAW = 15'h0010,
    ST_CWAIT = 15'h0020,
    ST_SCAN  = 15'h0040,
    ST_NDRAW = 15'h0080,
    ST_NWAIT = 15'h0100,
    ST_CV0   = 15'h0200,
    ST_CV1   = 15'h0400,
    ST_CV2   = 15'h0800,
    ST_POP   = 15'h1000,
    ST_LOAD  = 15'h2000,
    ST_QUERY = 15'h4000
  } state_t;

  state_t state;

  logic [4:0]       cell_mem [CELLS];
  logic [RW+CW-1:0] stack_mem [CELLS];

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [4:0]       mem_wdata;
  logic [IW-1:0]    mem_raddr;
  logic [4:0]       mem_rdata;
  logic             stk_we;
  logic [IW-1:0]    stk_waddr;
  logic [RW+CW-1:0] stk_wdata;
  logic [IW-1:0]    stk_raddr;
  logic [RW+CW-1:0] stk_rdata;

  logic [31:0]      rng;
  logic [IW-1:0]    clr_addr;
  logic [DW-1:0]    depth;
  logic [RW-1:0]    start_r;
  logic [RW-1:0]    cur_r;
  logic [CW-1:0]    cur_c;
  logic [RW-1:0]    nb_r;
  logic [CW-1:0]    nb_c;
  nb_dir_t          nb_k;
  nb_dir_t          cand [4];
  logic [2:0]       cand_n;
  logic [2:0]       cand_n_next;
  logic [2:0]       scan_cnt;
  logic [RW+CW-1:0] scan_pos;
  logic             pend_ok;
  logic             hit;
  logic             generated;
  logic             q_ok;
  logic [RW-1:0]    q_r;
  logic [CW-1:0]    q_c;
  logic [2:0]       q_dir;
  logic [3:0]       q_walls;
  logic             q_move;
  logic             in_grid;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  function automatic logic [IW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return IW'(IW'(r) * IW'(COLS) + IW'(c));
  endfunction

  function automatic logic nb_ok(input nb_dir_t d, input logic [RW-1:0] r,
                                 input logic [CW-1:0] c);
    logic ok;
    unique case (d)
      NB_N: ok = (r != '0);
      NB_S: ok = (r != RW'(ROWS - 1));
      NB_E: ok = (c != CW'(COLS - 1));
      NB_W: ok = (c != '0);
    endcase
    return ok;
  endfunction

  function automatic logic [RW+CW-1:0] nb_pos(input nb_dir_t d, input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    nr = r;
    nc = c;
    unique case (d)
      NB_N: nr = r - RW'(1);
      NB_S: nr = r + RW'(1);
      NB_E: nc = c + CW'(1);
      NB_W: nc = c - CW'(1);
    endcase
    return {nr, nc};
  endfunction

  rdm_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign busy = (state != ST_IDLE);

  assign in_grid = !request.row[7] && (request.row < 8'(ROWS))
                && !request.col[7] && (request.col < 8'(COLS));

  always_comb begin
    mod_req.start   = (state == ST_RDRAW) || (state == ST_CDRAW) || (state == ST_NDRAW);
    mod_req.value   = xorshift32(rng);
    mod_req.divisor = MOD_DW'(cand_n);
    if (state == ST_RDRAW) begin
      mod_req.divisor = MOD_DW'(ROWS);
    end else if (state == ST_CDRAW) begin
      mod_req.divisor = MOD_DW'(COLS);
    end
  end

  assign hit         = (scan_cnt != 3'd0) && pend_ok && !mem_rdata[4];
  assign cand_n_next = cand_n + {2'b00, hit};
  assign scan_pos    = nb_pos(nb_dir_t'(scan_cnt[1:0]), cur_r, cur_c);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = {1'b0, WALL_ALL};
    mem_raddr = cell_addr(cur_r, cur_c);
    stk_we    = 1'b0;
    stk_waddr = depth[IW-1:0];
    stk_wdata = {nb_r, nb_c};
    stk_raddr = IW'(depth - DW'(2));
    unique case (state)
      ST_IDLE: begin
        mem_raddr = cell_addr(request.row[RW-1:0], request.col[CW-1:0]);
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_CWAIT: begin
        if (mod_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(start_r, mod_rsp.rem[CW-1:0]);
          mem_wdata = {1'b1, WALL_ALL};
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {start_r, mod_rsp.rem[CW-1:0]};
        end
      end
      ST_SCAN: begin
        mem_raddr = cell_addr(scan_pos[RW+CW-1:CW], scan_pos[CW-1:0]);
      end
      ST_CV1: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(cur_r, cur_c);
        mem_wdata = {1'b1, mem_rdata[3:0] & ~wall_mine(nb_k)};
        mem_raddr = cell_addr(nb_r, nb_c);
      end
      ST_CV2: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(nb_r, nb_c);
        mem_wdata = {1'b1, mem_rdata[3:0] & ~wall_theirs(nb_k)};
        stk_we    = (depth < DW'(CELLS));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= cell_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stack_mem[stk_raddr];
  end

  always_comb begin
    q_walls = generated ? mem_rdata[3:0] : WALL_ALL;
    q_move  = 1'b0;
    unique case (q_dir)
      DIR_NORTH: q_move = (q_r != '0) && !q_walls[0];
      DIR_SOUTH: q_move = (q_r != RW'(ROWS - 1)) && !q_walls[2];
      DIR_EAST:  q_move = (q_c != CW'(COLS - 1)) && !q_walls[1];
      DIR_WEST:  q_move = (q_c != '0) && !q_walls[3];
      default:   q_move = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      generated <= 1'b0;
      depth     <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (request.mode == MODE_GEN) begin
              generated <= 1'b1;
              rng       <= (request.seed == 32'd0) ? 32'd1 : request.seed;
              clr_addr  <= '0;
              state     <= ST_CLEAR;
            end else begin
              q_ok  <= in_grid;
              q_r   <= request.row[RW-1:0];
              q_c   <= request.col[CW-1:0];
              q_dir <= request.direction;
              state <= ST_QUERY;
            end
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(CELLS - 1)) begin
            state <= ST_RDRAW;
          end
        end
        ST_RDRAW: begin
          rng   <= xorshift32(rng);
          state <= ST_RWAIT;
        end
        ST_RWAIT: begin
          if (mod_rsp.done) begin
            start_r <= mod_rsp.rem[RW-1:0];
            state   <= ST_CDRAW;
          end
        end
        ST_CDRAW: begin
          rng   <= xorshift32(rng);
          state <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (mod_rsp.done) begin
            cur_r    <= start_r;
            cur_c    <= mod_rsp.rem[CW-1:0];
            depth    <= DW'(1);
            scan_cnt <= '0;
            cand_n   <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_ok <= nb_ok(nb_dir_t'(scan_cnt[1:0]), cur_r, cur_c);
          if (hit) begin
            cand[cand_n[1:0]] <= nb_dir_t'(scan_cnt[1:0] - 2'd1);
          end
          cand_n   <= cand_n_next;
          scan_cnt <= scan_cnt + 3'd1;
          if (scan_cnt == 3'd4) begin
            state <= (cand_n_next == 3'd0) ? ST_POP : ST_NDRAW;
          end
        end
        ST_NDRAW: begin
          rng   <= xorshift32(rng);
          state <= ST_NWAIT;
        end
        ST_NWAIT: begin
          if (mod_rsp.done) begin
            nb_k         <= cand[mod_rsp.rem[1:0]];
            {nb_r, nb_c} <= nb_pos(cand[mod_rsp.rem[1:0]], cur_r, cur_c);
            state        <= ST_CV0;
          end
        end
        ST_CV0: begin
          state <= ST_CV1;
        end
        ST_CV1: begin
          state <= ST_CV2;
        end
        ST_CV2: begin
          if (depth < DW'(CELLS)) begin
            depth <= depth + DW'(1);
            cur_r <= nb_r;
            cur_c <= nb_c;
          end
          scan_cnt <= '0;
          cand_n   <= '0;
          state    <= ST_SCAN;
        end
        ST_POP: begin
          depth <= depth - DW'(1);
          if (depth == DW'(1)) begin
            strobe   <= 1'b1;
            response <= '{done_res: 1'b1, in_range: 1'b0, walls: 4'b0000, can_move: 1'b0};
            state    <= ST_IDLE;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          {cur_r, cur_c} <= stk_rdata;
          scan_cnt       <= '0;
          cand_n         <= '0;
          state          <= ST_SCAN;
        end
        ST_QUERY: begin
          strobe            <= 1'b1;
          response.done_res <= 1'b0;
          response.in_range <= q_ok;
          response.walls    <= q_ok ? q_walls : 4'b0000;
          response.can_move <= q_ok && q_move;
          state             <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/rdm_mod.sv -----
// Iterative remainder unit: value mod divisor, four dividend bits per cycle.
// Depends on rdm_pkg.
module rdm_mod (
  input  logic             clk,
  input  logic             rst,
  input  rdm_pkg::mod_req_t req,
  output rdm_pkg::mod_rsp_t rsp
);
  import rdm_pkg::*;

  logic [31:0]       val;
  logic [MOD_DW-1:0] div;
  logic [MOD_RW-1:0] rem;
  logic [MOD_RW-1:0] rem_next;
  logic [2:0]        cnt;
  logic              active;
  logic              done;

  always_comb begin
    logic [MOD_DW-1:0] t;
    rem_next = rem;
    for (int j = 0; j < 4; j++) begin
      t = {rem_next, val[31-j]};
      if (t >= div) begin
        t = t - div;
      end
      rem_next = t[MOD_RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(MOD_CYCLES - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val <= req.value;
      div <= req.divisor;
      rem <= '0;
    end else if (active) begin
      val <= {val[27:0], 4'b0000};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
